FILE: sv/sine_modulated_delay_flanger_core_defines.svh
`ifndef SINE_MODULATED_DELAY_FLANGER_CORE_DEFINES_SVH
`define SINE_MODULATED_DELAY_FLANGER_CORE_DEFINES_SVH

// Checked at every rising clock edge, masked while reset is high.
`define SMDF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SMDF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/smdf_pkg.sv
`default_nettype none
package smdf_pkg;

   localparam int SAMPLE_W = 16;

   typedef enum logic [1:0] {
      CSR_MIN_DELAY    = 2'd0,
      CSR_WIDTH        = 2'd1,
      CSR_PHASE_STEP   = 2'd2,
      CSR_BLOCK_LENGTH = 2'd3
   } csr_index_type;

   localparam logic [11:0] MIN_DELAY_RESET    = 12'd44;
   localparam logic [11:0] WIDTH_RESET        = 12'd441;
   localparam logic [15:0] PHASE_STEP_RESET   = 16'd256;
   localparam logic [12:0] BLOCK_LENGTH_RESET = 13'd512;
   localparam logic [12:0] BLOCK_LENGTH_MAX   = 13'd4096;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // sin(pi/2 * u), u and result in Q15
   function automatic longint quarter_sine(input longint u);
      longint u2;
      longint t;
      u2 = (u * u) >>> 15;
      t  = 2611 - ((u2 * 153) >>> 15);
      t  = 21167 - ((u2 * t) >>> 15);
      t  = 51472 - ((u2 * t) >>> 15);
      return (u * t) >>> 15;
   endfunction

endpackage
`default_nettype wire

FILE: sv/sine_modulated_delay_flanger_core.sv
`default_nettype none
// Flanger core: each sample is summed with the sample that lies the current delay behind it
// in a circular delay memory and saturated to 16 bits; the input sample itself is written
// into the memory. A sine LFO read from a constant table sets the delay at the start of each
// block. One transaction is taken every cycle while the output is not stalled; the pipeline
// is the sine table read, the width multiply, the delay wrap, the delay memory access and
// the output register. The delay memory needs no clearing pass after reset: a write pointer
// with a wrap flag marks slots not yet written, and those read as zero.
module sine_modulated_delay_flanger_core #(
   parameter int DELAY_DEPTH     = 8192,
   parameter int SINE_TABLE_SIZE = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] sample_out
   output logic [0:0]       rsp_tuser,   // [0] clipped
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int IW = $clog2(SINE_TABLE_SIZE);

   typedef logic signed [15:0] sine_rom_type [SINE_TABLE_SIZE];

   function automatic sine_rom_type build_sine();
      sine_rom_type tab;
      longint       q;
      longint       r;
      longint       v;
      logic [1:0]   quad;
      for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
         q    = (longint'(k) * 131072) / SINE_TABLE_SIZE;
         quad = 2'((q >> 15) & 3);
         r    = q & 32767;
         v    = quad[0] ? smdf_pkg::quarter_sine(32768 - r) : smdf_pkg::quarter_sine(r);
         if (v > 32767) begin
            v = 32767;
         end
         if (quad[1]) begin
            v = -v;
         end
         tab[k] = 16'(v);
      end
      return tab;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   function automatic logic [AW-1:0] wrap_delay(input logic [12:0] d);
      logic [19:0] r;
      r = 20'(d);
      for (int k = 2; k >= 0; k--) begin
         if (r >= (20'(DELAY_DEPTH) << k)) begin
            r = r - (20'(DELAY_DEPTH) << k);
         end
      end
      return AW'(r);
   endfunction

   logic signed [15:0] delay_mem [DELAY_DEPTH];

   logic [11:0] min_delay_ff;
   logic [11:0] width_ff;
   logic [15:0] phase_step_ff;
   logic [12:0] block_length_ff;

   logic [15:0]   lfo_phase_ff;
   logic [11:0]   block_pos_ff;
   logic [12:0]   cur_delay_ff;
   logic [AW-1:0] wp_ff;
   logic          wrapped_ff;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic               s1_blk_ff, s2_blk_ff;
   logic signed [15:0] s1_x_ff, s2_x_ff, s3_x_ff, s4_x_ff;
   logic signed [15:0] s1_sine_ff;
   logic [11:0]        s2_extra_ff;
   logic [AW-1:0]      s3_dmod_ff;
   logic               s4_fill_ff;
   logic signed [15:0] s4_data_ff;

   logic               out_valid_ff;
   logic [15:0]        out_data_ff;
   logic               out_clip_ff;

   logic          advance;
   logic          accept;
   logic [12:0]   len_in;
   logic [11:0]   pos_eff;
   logic [12:0]   pos_inc;
   logic          blk_start;
   logic [11:0]   block_pos_in;
   logic [15:0]   lfo_phase_in;
   logic [31:0]   idx_prod;
   logic [IW-1:0] sine_idx;
   logic [27:0]   width_prod;
   logic [12:0]   delay_new;
   logic [12:0]   delay_eff;
   logic [AW:0]   rd_diff;
   logic [AW-1:0] rd_addr;
   logic          rd_fill;
   logic [AW-1:0] wp_in;
   logic signed [15:0] tap;
   logic signed [16:0] sum_full;
   logic [15:0]        sum_sat;
   logic               clip;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_comb begin
      if (block_length_ff == 13'd0) begin
         len_in = 13'd1;
      end else if (block_length_ff > smdf_pkg::BLOCK_LENGTH_MAX) begin
         len_in = smdf_pkg::BLOCK_LENGTH_MAX;
      end else begin
         len_in = block_length_ff;
      end
      pos_eff      = (13'(block_pos_ff) >= len_in) ? 12'd0 : block_pos_ff;
      blk_start    = (pos_eff == 12'd0);
      pos_inc      = 13'(pos_eff) + 13'd1;
      block_pos_in = (pos_inc >= len_in) ? 12'd0 : pos_inc[11:0];
      lfo_phase_in = blk_start ? (lfo_phase_ff + phase_step_ff) : lfo_phase_ff;
      idx_prod     = 32'(lfo_phase_ff) * 32'(SINE_TABLE_SIZE);
      sine_idx     = idx_prod[16 +: IW];
   end

   assign width_prod = 28'(width_ff) * 28'(s1_sine_ff ^ 16'h8000);
   assign delay_new  = 13'(min_delay_ff) + 13'(s2_extra_ff);
   assign delay_eff  = s2_blk_ff ? delay_new : cur_delay_ff;

   always_comb begin
      rd_diff = {1'b0, wp_ff} - {1'b0, s3_dmod_ff};
      if (rd_diff[AW]) begin
         rd_addr = AW'(rd_diff + (AW+1)'(DELAY_DEPTH));
      end else begin
         rd_addr = rd_diff[AW-1:0];
      end
      rd_fill = wrapped_ff || (rd_addr < wp_ff);
      wp_in   = (wp_ff == AW'(DELAY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   end

   always_comb begin
      tap      = s4_fill_ff ? s4_data_ff : 16'sd0;
      sum_full = 17'(s4_x_ff) + 17'(tap);
      clip     = (sum_full[16] != sum_full[15]);
      if (!clip) begin
         sum_sat = sum_full[15:0];
      end else if (sum_full[16]) begin
         sum_sat = smdf_pkg::SAMPLE_MIN;
      end else begin
         sum_sat = smdf_pkg::SAMPLE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_delay_ff    <= smdf_pkg::MIN_DELAY_RESET;
         width_ff        <= smdf_pkg::WIDTH_RESET;
         phase_step_ff   <= smdf_pkg::PHASE_STEP_RESET;
         block_length_ff <= smdf_pkg::BLOCK_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            smdf_pkg::CSR_MIN_DELAY:    min_delay_ff    <= csr_wdata[11:0];
            smdf_pkg::CSR_WIDTH:        width_ff        <= csr_wdata[11:0];
            smdf_pkg::CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata;
            smdf_pkg::CSR_BLOCK_LENGTH: block_length_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_phase_ff <= '0;
         block_pos_ff <= '0;
         cur_delay_ff <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
         if (accept) begin
            lfo_phase_ff <= lfo_phase_in;
            block_pos_ff <= block_pos_in;
         end
         if (s2_valid_ff && s2_blk_ff) begin
            cur_delay_ff <= delay_new;
         end
         if (s3_valid_ff) begin
            wp_ff <= wp_in;
            if (wp_ff == AW'(DELAY_DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff     <= req_tdata;
         s1_blk_ff   <= blk_start;
         s1_sine_ff  <= SINE_ROM[sine_idx];
         s2_x_ff     <= s1_x_ff;
         s2_blk_ff   <= s1_blk_ff;
         s2_extra_ff <= width_prod[27:16];
         s3_x_ff     <= s2_x_ff;
         s3_dmod_ff  <= wrap_delay(delay_eff);
         s4_x_ff     <= s3_x_ff;
         s4_fill_ff  <= rd_fill;
         s4_data_ff  <= delay_mem[rd_addr];
         out_data_ff <= sum_sat;
         out_clip_ff <= clip;
         if (s3_valid_ff) begin
            delay_mem[wp_ff] <= s3_x_ff;
         end
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_clip_ff;

endmodule
`default_nettype wire

FILE: sv/smdf_checker.sv
`default_nettype none
`include "sine_modulated_delay_flanger_core_defines.svh"
module smdf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   `SMDF_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `SMDF_ASSERT(a_clip_rail, rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == smdf_pkg::SAMPLE_MAX || rsp_tdata == smdf_pkg::SAMPLE_MIN), "clipped result off the rail")
   `SMDF_ASSERT(a_ready_free, !rsp_tvalid |-> req_tready, "input blocked with output empty")
   `SMDF_ASSERT(a_stall_blocks, rsp_tvalid && !rsp_tready |-> !req_tready, "input taken during output stall")
   `SMDF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result after reset")

endmodule

bind sine_modulated_delay_flanger_core smdf_checker u_smdf_checker (.*);
`default_nettype wire
